>>> hdl/flm_pkg.sv
// ----------------------------------------------------------------------------
// flm_pkg
// Shared sizes, state codes and register indexes of the fire loop monitor.
// ----------------------------------------------------------------------------
package flm_pkg;

   // Sizing of the loop supervision.
   localparam int LINES            = 4;
   localparam int SAMPLES_LOG2     = 4;
   localparam int TICKS_PER_SECOND = 1000;
   localparam int SAMPLE_BITS      = 12;

   // Running sum of one averaging window never overflows this width.
   localparam int ACC_BITS = SAMPLE_BITS + SAMPLES_LOG2;
   localparam int CNT_BITS = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'((1 << SAMPLES_LOG2) - 1);

   // Line pointer and report bookkeeping.
   localparam int PTR_BITS  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int LEFT_BITS = $clog2(LINES + 1);
   localparam int LINE_BITS = 2;

   // Per-line timers saturate at all ones.
   localparam int TIMER_BITS = 18;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Register and field widths.
   localparam int MASK_BITS      = 4;
   localparam int DELAY_BITS     = 8;
   localparam int MV_BITS        = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   // Register reset values.
   localparam logic [MASK_BITS-1:0]  RST_ENABLE_MASK = 4'hF;
   localparam logic [TIMER_BITS-1:0] RST_FIRE_LIMIT  = TIMER_BITS'(5 * TICKS_PER_SECOND);
   localparam logic [TIMER_BITS-1:0] RST_FAULT_LIMIT = TIMER_BITS'(3 * TICKS_PER_SECOND);
   localparam logic [MV_BITS-1:0]    RST_OPEN_LOW    = 12'd200;
   localparam logic [MV_BITS-1:0]    RST_CLOSE_LOW   = 12'd800;
   localparam logic [MV_BITS-1:0]    RST_CLOSE_HIGH  = 12'd2000;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE_MASK = 3'd0,
      CSR_FIRE_DELAY  = 3'd1,
      CSR_FAULT_DELAY = 3'd2,
      CSR_OPEN_LOW    = 3'd3,
      CSR_CLOSE_LOW   = 3'd4,
      CSR_CLOSE_HIGH  = 3'd5
   } csr_index_type;

   // Physical loop condition as classified from the average.
   typedef enum logic [2:0] {
      PH_OPEN   = 3'd0,
      PH_CLOSED = 3'd1,
      PH_BREAK  = 3'd2,
      PH_SHORT  = 3'd3,
      PH_UNDEF  = 3'd4
   } phys_type;

   // Alarm machine states.
   typedef enum logic [1:0] {
      AL_OFF   = 2'd0,
      AL_ARMED = 2'd1,
      AL_ATTN  = 2'd2,
      AL_FIRE  = 2'd3
   } alarm_type;

   // Fault machine states.
   typedef enum logic [2:0] {
      FT_NORMAL  = 3'd0,
      FT_OPEN    = 3'd1,
      FT_CLOSED  = 3'd2,
      FT_PENDING = 3'd3,
      FT_SHORT   = 3'd4,
      FT_BREAK   = 3'd5
   } fault_type;

   // Input item kinds.
   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

endpackage

>>> hdl/flm_if.sv
// ----------------------------------------------------------------------------
// flm_if
// Valid/ready channels of the fire loop monitor: input items, reports and
// register writes.
// ----------------------------------------------------------------------------

// Input items: ADC samples and timer ticks.
interface flm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [flm_pkg::SAMPLE_BITS-1:0]     sample_mv;

   modport source (output valid, output kind, output sample_mv, input ready);
   modport sink   (input valid, input kind, input sample_mv, output ready);
endinterface

// Line reports.
interface flm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [flm_pkg::LINE_BITS-1:0]     line_index;
   logic [flm_pkg::MV_BITS-1:0]       average_mv;
   logic [2:0]                        physical_code;
   logic [1:0]                        alarm_code;
   logic [2:0]                        fault_code;
   logic                              last_report;

   modport source (output valid, output line_index, output average_mv,
                   output physical_code, output alarm_code, output fault_code,
                   output last_report, input ready);
   modport sink   (input valid, input line_index, input average_mv,
                   input physical_code, input alarm_code, input fault_code,
                   input last_report, output ready);
endinterface

// Register writes.
interface flm_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [flm_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [flm_pkg::CSR_DATA_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/fire_loop_monitor.sv
// ----------------------------------------------------------------------------
// fire_loop_monitor
// Supervises fire detector loops: averages ADC samples per line, classifies
// the loop condition and runs the alarm and fault machines on timer ticks.
// ----------------------------------------------------------------------------
// Path: an item passes the input register, then the update pass into the line
// state and the report sequencer, then the output register for each report.
// A tick yields one report per line, a full sample window one; the single
// report port delivers one line report per cycle while the receiver is ready.
// Reset (synchronous, active high) clears all line state and timers, empties
// the pipeline and loads the registers with their default values.
module fire_loop_monitor (
   input  logic             clock,
   input  logic             reset,
   flm_req_if.sink          req_bus,
   flm_rsp_if.source        rsp_bus,
   flm_csr_if.sink          csr_bus
);

   // Configuration registers; the delays are held pre-scaled to ticks.
   logic [flm_pkg::MASK_BITS-1:0]  enable_mask_ff;
   logic [flm_pkg::TIMER_BITS-1:0] fire_limit_ff;
   logic [flm_pkg::TIMER_BITS-1:0] fault_limit_ff;
   logic [flm_pkg::MV_BITS-1:0]    open_low_ff;
   logic [flm_pkg::MV_BITS-1:0]    close_low_ff;
   logic [flm_pkg::MV_BITS-1:0]    close_high_ff;

   // Input register.
   logic                             in_valid_ff;
   logic                             in_kind_ff;
   logic [flm_pkg::SAMPLE_BITS-1:0]  in_sample_ff;

   // Averaging state.
   logic [flm_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic [flm_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [flm_pkg::PTR_BITS-1:0]  ptr_ff, ptr_in;

   // Per-line state.
   logic [flm_pkg::MV_BITS-1:0]    average_ff     [flm_pkg::LINES];
   logic [flm_pkg::MV_BITS-1:0]    average_in     [flm_pkg::LINES];
   flm_pkg::phys_type              physical_ff    [flm_pkg::LINES];
   flm_pkg::phys_type              physical_in    [flm_pkg::LINES];
   flm_pkg::alarm_type             alarm_ff       [flm_pkg::LINES];
   flm_pkg::alarm_type             alarm_in       [flm_pkg::LINES];
   flm_pkg::fault_type             fault_ff       [flm_pkg::LINES];
   flm_pkg::fault_type             fault_in       [flm_pkg::LINES];
   logic [flm_pkg::TIMER_BITS-1:0] fire_timer_ff  [flm_pkg::LINES];
   logic [flm_pkg::TIMER_BITS-1:0] fire_timer_in  [flm_pkg::LINES];
   logic [flm_pkg::TIMER_BITS-1:0] fault_timer_ff [flm_pkg::LINES];
   logic [flm_pkg::TIMER_BITS-1:0] fault_timer_in [flm_pkg::LINES];

   // Report sequencer: reports still to deliver and the line of the next one.
   logic [flm_pkg::LEFT_BITS-1:0]  left_ff, left_in;
   logic [flm_pkg::PTR_BITS-1:0]   rpt_line_ff, rpt_line_in;

   // Output register.
   logic                             out_valid_ff;
   logic [flm_pkg::LINE_BITS-1:0]    out_line_ff;
   logic [flm_pkg::MV_BITS-1:0]      out_average_ff;
   flm_pkg::phys_type                out_physical_ff;
   flm_pkg::alarm_type               out_alarm_ff;
   flm_pkg::fault_type               out_fault_ff;
   logic                             out_last_ff;

   logic                             move;
   logic                             process;
   logic [flm_pkg::ACC_BITS-1:0]     sum;
   logic [flm_pkg::MV_BITS-1:0]      avg;

   // Threshold classification of one averaged voltage.
   function automatic flm_pkg::phys_type classify(
      input logic [flm_pkg::MV_BITS-1:0] v,
      input logic [flm_pkg::MV_BITS-1:0] open_low,
      input logic [flm_pkg::MV_BITS-1:0] close_low,
      input logic [flm_pkg::MV_BITS-1:0] close_high
   );
      flm_pkg::phys_type ph;
      if (v < open_low) begin
         ph = flm_pkg::PH_BREAK;
      end else if (v < close_low) begin
         ph = flm_pkg::PH_OPEN;
      end else if (v <= close_high) begin
         ph = flm_pkg::PH_CLOSED;
      end else begin
         ph = flm_pkg::PH_SHORT;
      end
      return ph;
   endfunction

   // Handshakes. A new item is processed once the previous reports are out
   // of the sequencer or the last of them leaves in this cycle.
   assign move    = (left_ff != '0) && (!out_valid_ff || rsp_bus.ready);
   assign process = in_valid_ff &&
                    ((left_ff == '0) ||
                     ((left_ff == flm_pkg::LEFT_BITS'(1)) && move));
   assign req_bus.ready = !in_valid_ff || process;
   assign csr_bus.ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= flm_pkg::RST_ENABLE_MASK;
         fire_limit_ff  <= flm_pkg::RST_FIRE_LIMIT;
         fault_limit_ff <= flm_pkg::RST_FAULT_LIMIT;
         open_low_ff    <= flm_pkg::RST_OPEN_LOW;
         close_low_ff   <= flm_pkg::RST_CLOSE_LOW;
         close_high_ff  <= flm_pkg::RST_CLOSE_HIGH;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            flm_pkg::CSR_ENABLE_MASK: begin
               enable_mask_ff <= csr_bus.data[flm_pkg::MASK_BITS-1:0];
            end
            flm_pkg::CSR_FIRE_DELAY: begin
               fire_limit_ff <= flm_pkg::TIMER_BITS'(
                  csr_bus.data[flm_pkg::DELAY_BITS-1:0] * flm_pkg::TICKS_PER_SECOND);
            end
            flm_pkg::CSR_FAULT_DELAY: begin
               fault_limit_ff <= flm_pkg::TIMER_BITS'(
                  csr_bus.data[flm_pkg::DELAY_BITS-1:0] * flm_pkg::TICKS_PER_SECOND);
            end
            flm_pkg::CSR_OPEN_LOW: begin
               open_low_ff <= csr_bus.data[flm_pkg::MV_BITS-1:0];
            end
            flm_pkg::CSR_CLOSE_LOW: begin
               close_low_ff <= csr_bus.data[flm_pkg::MV_BITS-1:0];
            end
            flm_pkg::CSR_CLOSE_HIGH: begin
               close_high_ff <= csr_bus.data[flm_pkg::MV_BITS-1:0];
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_kind_ff   <= req_bus.kind;
         in_sample_ff <= req_bus.sample_mv;
      end
   end

   // Update pass: one sample step, or one tick step over all lines in parallel.
   always_comb begin
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      average_in     = average_ff;
      physical_in    = physical_ff;
      alarm_in       = alarm_ff;
      fault_in       = fault_ff;
      fire_timer_in  = fire_timer_ff;
      fault_timer_in = fault_timer_ff;
      sum            = acc_ff + flm_pkg::ACC_BITS'(in_sample_ff);
      avg            = sum[flm_pkg::ACC_BITS-1:flm_pkg::SAMPLES_LOG2];

      // Sequencer: drain one report per move, reload when an item is done.
      left_in     = left_ff;
      rpt_line_in = rpt_line_ff;
      if (move) begin
         left_in     = left_ff - flm_pkg::LEFT_BITS'(1);
         rpt_line_in = (rpt_line_ff == flm_pkg::PTR_BITS'(flm_pkg::LINES - 1)) ?
                       '0 : rpt_line_ff + flm_pkg::PTR_BITS'(1);
      end

      if (process) begin
         if (in_kind_ff == flm_pkg::KIND_SAMPLE) begin
            // Accumulate; on the last sample of a window store the average.
            if (cnt_ff == flm_pkg::CNT_LAST) begin
               average_in[ptr_ff]  = avg;
               physical_in[ptr_ff] = classify(avg, open_low_ff, close_low_ff,
                                              close_high_ff);
               acc_in      = '0;
               cnt_in      = '0;
               ptr_in      = (ptr_ff == flm_pkg::PTR_BITS'(flm_pkg::LINES - 1)) ?
                             '0 : ptr_ff + flm_pkg::PTR_BITS'(1);
               left_in     = flm_pkg::LEFT_BITS'(1);
               rpt_line_in = ptr_ff;
            end else begin
               acc_in = sum;
               cnt_in = cnt_ff + flm_pkg::CNT_BITS'(1);
            end
         end else begin
            for (int i = 0; i < flm_pkg::LINES; i++) begin
               // Timers advance first, saturating.
               if (fire_timer_ff[i] != flm_pkg::TIMER_MAX) begin
                  fire_timer_in[i] = fire_timer_ff[i] + flm_pkg::TIMER_BITS'(1);
               end
               if (fault_timer_ff[i] != flm_pkg::TIMER_MAX) begin
                  fault_timer_in[i] = fault_timer_ff[i] + flm_pkg::TIMER_BITS'(1);
               end

               // Alarm machine.
               unique case (alarm_ff[i])
                  flm_pkg::AL_OFF: begin
                     if (enable_mask_ff[i % flm_pkg::MASK_BITS]) begin
                        alarm_in[i] = flm_pkg::AL_ARMED;
                     end
                  end
                  flm_pkg::AL_ARMED: begin
                     if (physical_ff[i] == flm_pkg::PH_CLOSED) begin
                        fire_timer_in[i] = '0;
                        alarm_in[i]      = flm_pkg::AL_ATTN;
                     end
                     if (!enable_mask_ff[i % flm_pkg::MASK_BITS]) begin
                        alarm_in[i] = flm_pkg::AL_OFF;
                     end
                  end
                  flm_pkg::AL_ATTN: begin
                     if (physical_ff[i] == flm_pkg::PH_CLOSED) begin
                        if (fire_timer_in[i] >= fire_limit_ff) begin
                           alarm_in[i] = flm_pkg::AL_FIRE;
                        end
                     end else begin
                        alarm_in[i] = flm_pkg::AL_ARMED;
                     end
                  end
                  flm_pkg::AL_FIRE: begin
                     if (physical_ff[i] == flm_pkg::PH_OPEN) begin
                        alarm_in[i] = flm_pkg::AL_ARMED;
                     end
                  end
                  default: begin
                     alarm_in[i] = alarm_ff[i];
                  end
               endcase

               // Fault machine; a disabled line is held at normal.
               if (!enable_mask_ff[i % flm_pkg::MASK_BITS]) begin
                  fault_in[i] = flm_pkg::FT_NORMAL;
               end else begin
                  unique case (fault_ff[i])
                     flm_pkg::FT_NORMAL, flm_pkg::FT_OPEN, flm_pkg::FT_CLOSED: begin
                        if (physical_ff[i] == flm_pkg::PH_CLOSED) begin
                           fault_in[i] = flm_pkg::FT_CLOSED;
                        end else if (physical_ff[i] == flm_pkg::PH_OPEN) begin
                           fault_in[i] = flm_pkg::FT_OPEN;
                        end else begin
                           fault_in[i]       = flm_pkg::FT_PENDING;
                           fault_timer_in[i] = '0;
                        end
                     end
                     flm_pkg::FT_PENDING: begin
                        if (physical_ff[i] == flm_pkg::PH_BREAK ||
                            physical_ff[i] == flm_pkg::PH_SHORT) begin
                           if (fault_timer_in[i] >= fault_limit_ff) begin
                              fault_in[i] = (physical_ff[i] == flm_pkg::PH_SHORT) ?
                                            flm_pkg::FT_SHORT : flm_pkg::FT_BREAK;
                           end
                        end else begin
                           fault_in[i] = flm_pkg::FT_NORMAL;
                        end
                     end
                     flm_pkg::FT_SHORT: begin
                        if (physical_ff[i] != flm_pkg::PH_SHORT) begin
                           fault_in[i]       = flm_pkg::FT_PENDING;
                           fault_timer_in[i] = '0;
                        end
                     end
                     flm_pkg::FT_BREAK: begin
                        if (physical_ff[i] != flm_pkg::PH_BREAK) begin
                           fault_in[i]       = flm_pkg::FT_PENDING;
                           fault_timer_in[i] = '0;
                        end
                     end
                     default: begin
                        fault_in[i] = fault_ff[i];
                     end
                  endcase
               end
            end
            left_in     = flm_pkg::LEFT_BITS'(flm_pkg::LINES);
            rpt_line_in = '0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         cnt_ff      <= '0;
         ptr_ff      <= '0;
         left_ff     <= '0;
         rpt_line_ff <= '0;
         for (int i = 0; i < flm_pkg::LINES; i++) begin
            average_ff[i]     <= '0;
            physical_ff[i]    <= flm_pkg::PH_OPEN;
            alarm_ff[i]       <= flm_pkg::AL_OFF;
            fault_ff[i]       <= flm_pkg::FT_NORMAL;
            fire_timer_ff[i]  <= '0;
            fault_timer_ff[i] <= '0;
         end
      end else begin
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         ptr_ff         <= ptr_in;
         left_ff        <= left_in;
         rpt_line_ff    <= rpt_line_in;
         average_ff     <= average_in;
         physical_ff    <= physical_in;
         alarm_ff       <= alarm_in;
         fault_ff       <= fault_in;
         fire_timer_ff  <= fire_timer_in;
         fault_timer_ff <= fault_timer_in;
      end
   end

   // Output register: valid is control, the report fields are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_line_ff     <= flm_pkg::LINE_BITS'(rpt_line_ff);
         out_average_ff  <= average_ff[rpt_line_ff];
         out_physical_ff <= (alarm_ff[rpt_line_ff] == flm_pkg::AL_OFF) ?
                            flm_pkg::PH_UNDEF : physical_ff[rpt_line_ff];
         out_alarm_ff    <= alarm_ff[rpt_line_ff];
         out_fault_ff    <= fault_ff[rpt_line_ff];
         out_last_ff     <= (left_ff == flm_pkg::LEFT_BITS'(1));
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.line_index    = out_line_ff;
   assign rsp_bus.average_mv    = out_average_ff;
   assign rsp_bus.physical_code = out_physical_ff;
   assign rsp_bus.alarm_code    = out_alarm_ff;
   assign rsp_bus.fault_code    = out_fault_ff;
   assign rsp_bus.last_report   = out_last_ff;

endmodule

>>> hdl/flm_checker.sv
// ----------------------------------------------------------------------------
// flm_checker
// Port-level checks of the fire loop monitor, bound to the top level.
// ----------------------------------------------------------------------------
module flm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_line_index,
   input logic [2:0]  rsp_physical_code,
   input logic [1:0]  rsp_alarm_code,
   input logic [2:0]  rsp_fault_code,
   input logic        rsp_last_report
);

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report valid after reset");

   // The physical code reads undefined exactly when the alarm machine is off.
   a_undef_iff_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_physical_code == flm_pkg::PH_UNDEF) ==
                     (rsp_alarm_code == flm_pkg::AL_OFF)))
      else $error("physical code and alarm state disagree");

   // Only tick reports of lines before the last one go out unflagged.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_report) |->
         (rsp_line_index != 2'(flm_pkg::LINES - 1)))
      else $error("final line report not flagged as last");

   // Codes stay within their defined ranges.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_physical_code <= flm_pkg::PH_UNDEF) &&
                     (rsp_fault_code <= flm_pkg::FT_BREAK)))
      else $error("report code out of range");

   // A stalled report holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_line_index) && $stable(rsp_last_report)))
      else $error("stalled report changed");

endmodule

bind fire_loop_monitor flm_checker u_flm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_line_index    (rsp_bus.line_index),
   .rsp_physical_code (rsp_bus.physical_code),
   .rsp_alarm_code    (rsp_bus.alarm_code),
   .rsp_fault_code    (rsp_bus.fault_code),
   .rsp_last_report   (rsp_bus.last_report)
);
